@@ rtl/core/nbc_pkg.sv @@
// Shared types, codes and helpers for the nucleotide bigram counter.
// No dependencies; used by nbc_stats and nucleotide_bigram_counter.
package nbc_pkg;

  // Default sizes of the counters and of the line length register
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int SUM_WIDTH        = 64;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_TEXT = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Statistic indexes
  localparam logic [4:0] STAT_LINES   = 5'd0;
  localparam logic [4:0] STAT_BASES   = 5'd1;
  localparam logic [4:0] STAT_BASE_A  = 5'd2;
  localparam logic [4:0] STAT_PAIRS   = 5'd6;
  localparam logic [4:0] STAT_PAIR_AA = 5'd7;
  localparam logic [4:0] STAT_SQUARES = 5'd23;
  localparam int         STAT_COUNT   = 24;

  // Upper-case letters; the lower-case form differs only in bit 5
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  // Base codes, order A C T G
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_T = 2'd2;
  localparam logic [1:0] BASE_G = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_dec_t;

  // Per-cycle update command from the front end to the counter bank
  typedef struct packed {
    logic       text;  // a kept base arrives
    logic       eol;   // end of line
    logic [1:0] base;
  } nbc_op_t;

  // Fold case and map A C T G to 0..3
  function automatic base_dec_t base_decode(input logic [7:0] ch);
    base_dec_t  d;
    logic [7:0] up;
    up = ch & CASE_MASK;
    d.ok = 1'b1;
    case (up)
      CHAR_A:  d.code = BASE_A;
      CHAR_C:  d.code = BASE_C;
      CHAR_T:  d.code = BASE_T;
      CHAR_G:  d.code = BASE_G;
      default: begin
        d.ok   = 1'b0;
        d.code = BASE_A;
      end
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/nbc_stats.sv @@
// Counter bank: base, bigram, line and total counters plus the sum of
// squared line lengths, with the statistic read select. Uses nbc_pkg.
module nbc_stats
  import nbc_pkg::*;
#(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nbc_op_t              op,
  input  logic [4:0]           rd_index,
  output logic [SUM_WIDTH-1:0] rd_value
);

  localparam int SQ_WIDTH = 2 * LENGTH_WIDTH;

  logic [COUNT_WIDTH-1:0]  line_total;
  logic [COUNT_WIDTH-1:0]  base_total;
  logic [COUNT_WIDTH-1:0]  pair_total;
  logic [COUNT_WIDTH-1:0]  base_cnt [4];
  logic [COUNT_WIDTH-1:0]  pair_cnt [16];
  logic [LENGTH_WIDTH-1:0] line_len;
  logic [SQ_WIDTH-1:0]     line_sq;
  logic [SUM_WIDTH-1:0]    square_sum;
  logic                    half_valid;
  logic [1:0]              half_base;

  logic [3:0]              pair_sel;
  logic                    pair_hit;
  logic                    len_full;
  logic [SQ_WIDTH-1:0]     line_sq_next;
  logic [SUM_WIDTH:0]      sum_wide;
  logic [SUM_WIDTH-1:0]    square_sum_next;
  logic [SUM_WIDTH-1:0]    stat_vec [STAT_COUNT];

  // Saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // Bigram formed by this base and the waiting one
  assign pair_sel = {half_base, op.base};
  assign pair_hit = op.text && half_valid;

  // Running square of the line length: (n+1)^2 = n^2 + 2n + 1
  assign len_full     = &line_len;
  assign line_sq_next = line_sq + SQ_WIDTH'({line_len, 1'b1});

  // Saturating add of the finished line's square
  assign sum_wide        = {1'b0, square_sum} + (SUM_WIDTH + 1)'(line_sq);
  assign square_sum_next = sum_wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];

  // Counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      line_total <= '0;
      base_total <= '0;
      pair_total <= '0;
      line_len   <= '0;
      line_sq    <= '0;
      square_sum <= '0;
      half_valid <= 1'b0;
      half_base  <= '0;
      for (int i = 0; i < 4; i++) base_cnt[i] <= '0;
      for (int i = 0; i < 16; i++) pair_cnt[i] <= '0;
    end else if (op.text) begin
      base_cnt[op.base] <= sat_inc(base_cnt[op.base]);
      base_total        <= sat_inc(base_total);
      if (!len_full) begin
        line_len <= line_len + LENGTH_WIDTH'(1);
        line_sq  <= line_sq_next;
      end
      if (pair_hit) begin
        pair_cnt[pair_sel] <= sat_inc(pair_cnt[pair_sel]);
        pair_total         <= sat_inc(pair_total);
        half_valid         <= 1'b0;
      end else begin
        half_base  <= op.base;
        half_valid <= 1'b1;
      end
    end else if (op.eol) begin
      line_total <= sat_inc(line_total);
      square_sum <= square_sum_next;
      line_len   <= '0;
      line_sq    <= '0;
      half_valid <= 1'b0;
    end
  end

  // Flat view of all statistics in index order
  always_comb begin
    stat_vec[STAT_LINES]   = SUM_WIDTH'(line_total);
    stat_vec[STAT_BASES]   = SUM_WIDTH'(base_total);
    stat_vec[STAT_PAIRS]   = SUM_WIDTH'(pair_total);
    stat_vec[STAT_SQUARES] = square_sum;
    for (int i = 0; i < 4; i++) stat_vec[int'(STAT_BASE_A) + i] = SUM_WIDTH'(base_cnt[i]);
    for (int i = 0; i < 16; i++) stat_vec[int'(STAT_PAIR_AA) + i] = SUM_WIDTH'(pair_cnt[i]);
  end

  // Read select; unused indexes read zero
  assign rd_value = (rd_index < 5'(STAT_COUNT)) ? stat_vec[rd_index] : '0;

endmodule

@@ rtl/core/nucleotide_bigram_counter.sv @@
// Nucleotide and bigram histogram, top level. A read word passes through the
// input register, then the result register, which raises m_tvalid for its
// result word. Throughput: one word per cycle; a read waits in the input
// register only while the result register is full and not being taken.
// Reset (rst, synchronous) clears all counters, the line state and the valid flags of both registers.
module nucleotide_bigram_counter
  import nbc_pkg::*;
#(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], stat_index[12:8], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // stat_echo[4:0], stat_value[68:5], zero pad
);

  // Input register
  logic                 in_valid;
  logic [1:0]           in_req;
  logic [7:0]           in_char;
  logic [4:0]           in_index;

  // Result register
  logic [4:0]           out_echo;
  logic [SUM_WIDTH-1:0] out_value;

  logic                 out_free;
  logic                 proc;
  logic                 in_take;
  base_dec_t            dec;
  nbc_op_t              op;
  logic [SUM_WIDTH-1:0] rd_value;

  // The held word moves on unless it is a read facing a full result register
  assign out_free = !m_tvalid || m_tready;
  assign proc     = in_valid && ((in_req != REQ_READ) || out_free);
  assign s_tready = !in_valid || proc;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req   <= s_tuser;
      in_char  <= s_tdata[7:0];
      in_index <= s_tdata[12:8];
    end
  end

  // Decode into a counter update
  assign dec     = base_decode(in_char);
  assign op.text = proc && (in_req == REQ_TEXT) && dec.ok;
  assign op.eol  = proc && (in_req == REQ_EOL);
  assign op.base = dec.code;

  nbc_stats #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_stats (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .rd_index (in_index),
    .rd_value (rd_value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc && (in_req == REQ_READ)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (in_req == REQ_READ)) begin
      out_echo  <= in_index;
      out_value <= rd_value;
    end
  end

  assign m_tdata = {3'b000, out_value, out_echo};

  // A new result only follows a read leaving the input register
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid && (in_req == REQ_READ)))
    else $error("result without a read");

  // Input stalls only on a read blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && (in_req == REQ_READ) && m_tvalid && !m_tready))
    else $error("input stalled without cause");

  // A blocked read keeps its index
  a_held_read: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !proc) |=> (in_valid && $stable(in_index) && $stable(in_req)))
    else $error("blocked read lost");

  // Counter updates never come from an empty input register
  a_op_needs_item: assert property (@(posedge clk) disable iff (rst)
    (op.text || op.eol) |-> in_valid)
    else $error("update without item");

endmodule
